[rtl/assert_macros.svh]
// assertion macros for the rtl files that check their own logic (used by the top level)
// depends on a clock named clk_i and an active-low reset named rst_ni in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/p2qe_pkg.sv]
// shared types and constants of the streaming quantile estimator
// used by every module of the block, no dependencies
package p2qe_pkg;

  localparam int FIELD_W   = 20;
  localparam int QF_W      = 16;
  localparam logic [QF_W-1:0] QF_RESET = 16'd64881;
  localparam int POS_W     = 32;
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 33;
  localparam int PP_W      = 65;
  localparam int PROD_W    = 97;
  localparam int DEN_W     = 97;
  localparam int CLAMP_BIT = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_EVAL,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_NUM,
    ST_LIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MOP_FA_GLO,
    MOP_A_DH,
    MOP_FB_GHI,
    MOP_B_DH,
    MOP_GHI_GLO,
    MOP_DEN
  } mop_e;

  typedef struct packed {
    logic       warm;
    logic       update;
    logic       sort_en;
    logic       sort_odd;
    logic       mul_start;
    mop_e       mop;
    logic       num_par;
    logic       num_lin;
    logic       div_start;
    logic       write;
    logic [2:0] idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic seen_full;
    logic last_warm;
    logic move;
    logic gaps_nz;
    logic mul_done;
    logic div_done;
    logic yp_ok;
    logic den_nz;
  } sts_t;

endpackage

[rtl/p2_streaming_quantile_estimator.sv]
// top level of the streaming quantile estimator (five-marker p-square scheme)
// depends on p2qe_pkg, p2qe_ctrl, p2qe_dp and assert_macros.svh
//
// usage: one delay sample per input item on sample_value_i (valid/stall);
// one result item per input item on quantile_estimate_o / estimate_ready_o.
// cfg_wdata_i is the target quantile (q0.16); the user must assert cfg_we_i only
// while the block is idle, since the block itself does not enforce it.
// items are processed one at a time; in_stall_o is low only while idle.
// steps from the accepting edge to the edge that raises out_valid_o:
//   first four samples: stored directly; fifth sample: a 5-step sort;
//   later samples: the cell update, then per inner marker a check that
//   ends there when it holds, or six multiplies and one division when it
//   moves, plus a second division on a linear fallback; a zero gap goes
//   straight to the linear height (one division).
// the next item is accepted in the cycle after the result is loaded; an item's
//   time is dominated by the bit-serial divider (SAMPLE_BITS+65 steps).
// the finished result sits in an output register, so a stalled receiver
// holds it while the next item is already being processed.
// reset clears all marker state and valid, and sets the quantile to 0.99.
module p2_streaming_quantile_estimator #(
  parameter int SAMPLE_BITS        = 20,
  parameter int POSITION_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [p2qe_pkg::QF_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [p2qe_pkg::FIELD_W-1:0]  sample_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [p2qe_pkg::FIELD_W-1:0]  quantile_estimate_o,
  output logic                          estimate_ready_o
);

  p2qe_pkg::cmd_t cmd;
  p2qe_pkg::sts_t sts;

  logic                          in_ready;
  logic                          in_accept;
  logic                          out_free;
  logic                          out_load;
  logic [p2qe_pkg::FIELD_W-1:0]  estimate;
  logic [p2qe_pkg::FIELD_W-1:0]  est_q;
  logic                          rdy_q;
  logic                          out_valid_q;

  assign in_accept = in_valid_i && in_ready;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = cmd.out_load;

  p2qe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  p2qe_dp #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_value_i (sample_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .estimate_o     (estimate)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      est_q       <= '0;
      rdy_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        est_q       <= estimate;
        rdy_q       <= sts.seen_full;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o          = !in_ready;
  assign out_valid_o         = out_valid_q;
  assign quantile_estimate_o = est_q;
  assign estimate_ready_o    = rdy_q;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_load_blocks_input, out_load, in_stall_o && !in_accept)
  `ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_o)
  `ASSERT_NEXT(a_ready_sticky, estimate_ready_o, estimate_ready_o)
  `ASSERT_IMPLY(a_div_den_nonzero, cmd.div_start, sts.den_nz)

endmodule

[rtl/p2qe_mul.sv]
// sequential multiplier, 64 by 33 bits as two 32 by 33 partial products
// depends on p2qe_pkg for operand and product widths
module p2qe_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [p2qe_pkg::MUL_A_W-1:0]  a_i,
  input  logic [p2qe_pkg::MUL_B_W-1:0]  b_i,
  output logic                          done_o,
  output logic [p2qe_pkg::PROD_W-1:0]   prod_o
);

  localparam int AW = p2qe_pkg::MUL_A_W;
  localparam int BW = p2qe_pkg::MUL_B_W;
  localparam int PW = p2qe_pkg::PP_W;
  localparam int RW = p2qe_pkg::PROD_W;
  localparam int HW = AW / 2;

  logic [AW-1:0] a_q;
  logic [BW-1:0] b_q;
  logic [PW-1:0] pp_q;
  logic [RW-1:0] acc_q;
  logic [1:0]    step_q;
  logic          busy_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      case (step_q)
        2'd0: pp_q <= PW'(a_q[HW-1:0] * b_q);
        2'd1: begin
          acc_q <= RW'(pp_q);
          pp_q  <= PW'(a_q[AW-1:HW] * b_q);
        end
        2'd2: acc_q <= acc_q + (RW'(pp_q) << HW);
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[rtl/p2qe_div.sv]
// restoring divider, one quotient bit per cycle, with remainder-nonzero flag
// depends on p2qe_pkg for the divisor width
module p2qe_div #(
  parameter int NUM_W = 85
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NUM_W-1:0]            num_i,
  input  logic [p2qe_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [NUM_W-1:0]            quot_o,
  output logic                        inexact_o
);

  localparam int DW = p2qe_pkg::DEN_W;
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             ge;
  logic [DW-1:0]    rem_nx;

  always_comb begin
    rem_sh  = {rem_q, nq_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_nx  = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[NUM_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o    = done_q;
  assign quot_o    = nq_q;
  assign inexact_o = |rem_q;

endmodule

[rtl/p2qe_dp.sv]
// datapath: marker state, cell update, sort network step, marker height arithmetic
// depends on p2qe_pkg, p2qe_mul and p2qe_div
module p2qe_dp #(
  parameter int SAMPLE_BITS        = 20,
  parameter int POSITION_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [p2qe_pkg::QF_W-1:0]     cfg_wdata_i,
  input  logic [p2qe_pkg::FIELD_W-1:0]  sample_value_i,
  input  p2qe_pkg::cmd_t                cmd_i,
  output p2qe_pkg::sts_t                sts_o,
  output logic [p2qe_pkg::FIELD_W-1:0]  estimate_o
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = POSITION_FRAC_BITS;
  localparam int PW    = p2qe_pkg::POS_W;
  localparam int QW    = p2qe_pkg::QF_W;
  localparam int FW    = p2qe_pkg::FIELD_W;
  localparam int DW    = PW + F;
  localparam int MA    = p2qe_pkg::MUL_A_W;
  localparam int MB    = p2qe_pkg::MUL_B_W;
  localparam int RW    = p2qe_pkg::PROD_W;
  localparam int EW    = p2qe_pkg::DEN_W;
  localparam int CB    = p2qe_pkg::CLAMP_BIT;
  localparam int AW    = S + MA;
  localparam int NUM_W = AW + 1;
  localparam int NW    = AW + 2;
  localparam int VW    = ((S > CB + 1) ? S : CB + 1) + 2;
  localparam logic [DW-1:0] PONE   = DW'(1) << F;
  localparam logic [CB:0]   QCLAMP = {1'b1, {CB{1'b0}}};

  logic [QW-1:0] qf_q;
  logic [S-1:0]  h_q  [5];
  logic [PW-1:0] p_q  [5];
  logic [DW-1:0] ds_q [5];
  logic [2:0]    seen_q;

  logic [MA-1:0]    tmp_q;
  logic [AW-1:0]    a_q;
  logic [AW-1:0]    b_q;
  logic [EW-1:0]    den_q;
  logic [NUM_W-1:0] mag_q;
  logic             neg_q;

  logic [S-1:0]   q;
  logic [QW+F-1:0] ps;
  logic [QW+F:0]   ps3;
  logic [DW-1:0]  inc [5];
  logic [DW-1:0]  init1, init2, init3, init4;
  logic [2:0]     k;

  logic [S-1:0]  iy, yi, yii;
  logic [PW-1:0] pl, pi, ph;
  logic [DW-1:0] di, diff, ndiff;
  logic [PW-1:0] g_lo, g_hi;
  logic          dpos, up, dn;
  logic [S:0]    dh_hi, dh_lo, ndh_hi, ndh_lo;
  logic [S-1:0]  dh_hi_mag, dh_lo_mag;
  logic [MB-1:0] fa, fb, gsum;

  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic          mul_done;
  logic [RW-1:0] mul_prod;

  logic [NW-1:0]    sa, sb, nsum, nfin, nabs;
  logic [S+1:0]     ln, lnabs;

  logic             div_done;
  logic [NUM_W-1:0] quot;
  logic             inexact;
  logic             big;
  logic [CB:0]      qm;
  logic [VW-1:0]    qmi, fl, v0, v;
  logic             yp_ok;
  logic [PW-1:0]    p_new;

  assign q   = S'(sample_value_i);
  assign ps  = {qf_q, {F{1'b0}}};
  assign ps3 = {1'b1, qf_q, {F{1'b0}}};

  always_comb begin
    inc[0] = '0;
    inc[1] = DW'(ps >> 17);
    inc[2] = DW'(ps >> 16);
    inc[3] = DW'(ps3 >> 17);
    inc[4] = PONE;
    init1  = PONE + DW'(ps >> 15);
    init2  = PONE + DW'(ps >> 14);
    init3  = (PONE << 1) + PONE + DW'(ps >> 15);
    init4  = (PONE << 2) + PONE;
  end

  // cell of the new sample
  always_comb begin
    if (q < h_q[1]) begin
      k = 3'd1;
    end else if (q < h_q[2]) begin
      k = 3'd2;
    end else if (q < h_q[3]) begin
      k = 3'd3;
    end else begin
      k = 3'd4;
    end
  end

  // neighborhood of the marker under adjustment
  always_comb begin
    case (cmd_i.idx)
      3'd2: begin
        iy = h_q[1]; yi = h_q[2]; yii = h_q[3];
        pl = p_q[1]; pi = p_q[2]; ph  = p_q[3];
        di = ds_q[2];
      end
      3'd3: begin
        iy = h_q[2]; yi = h_q[3]; yii = h_q[4];
        pl = p_q[2]; pi = p_q[3]; ph  = p_q[4];
        di = ds_q[3];
      end
      default: begin
        iy = h_q[0]; yi = h_q[1]; yii = h_q[2];
        pl = p_q[0]; pi = p_q[1]; ph  = p_q[2];
        di = ds_q[1];
      end
    endcase
  end

  always_comb begin
    diff      = di - {pi, {F{1'b0}}};
    ndiff     = -diff;
    dpos      = !diff[DW-1];
    g_lo      = pi - pl;
    g_hi      = ph - pi;
    up        = dpos && (diff >= PONE) && (g_hi > PW'(1));
    dn        = !dpos && (ndiff >= PONE) && (g_lo > PW'(1));
    dh_hi     = {1'b0, yii} - {1'b0, yi};
    dh_lo     = {1'b0, yi} - {1'b0, iy};
    ndh_hi    = -dh_hi;
    ndh_lo    = -dh_lo;
    dh_hi_mag = dh_hi[S] ? ndh_hi[S-1:0] : dh_hi[S-1:0];
    dh_lo_mag = dh_lo[S] ? ndh_lo[S-1:0] : dh_lo[S-1:0];
    fa        = dpos ? {1'b0, g_lo} + MB'(1) : {1'b0, g_lo} - MB'(1);
    fb        = dpos ? {1'b0, g_hi} - MB'(1) : {1'b0, g_hi} + MB'(1);
    gsum      = {1'b0, g_lo} + {1'b0, g_hi};
    p_new     = dpos ? pi + PW'(1) : pi - PW'(1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mop)
      p2qe_pkg::MOP_FA_GLO: begin
        mul_a = MA'(g_lo);
        mul_b = fa;
      end
      p2qe_pkg::MOP_A_DH: begin
        mul_a = tmp_q;
        mul_b = MB'(dh_hi_mag);
      end
      p2qe_pkg::MOP_FB_GHI: begin
        mul_a = MA'(g_hi);
        mul_b = fb;
      end
      p2qe_pkg::MOP_B_DH: begin
        mul_a = tmp_q;
        mul_b = MB'(dh_lo_mag);
      end
      p2qe_pkg::MOP_GHI_GLO: begin
        mul_a = MA'(g_hi);
        mul_b = MB'(g_lo);
      end
      p2qe_pkg::MOP_DEN: begin
        mul_a = tmp_q;
        mul_b = gsum;
      end
      default: ;
    endcase
  end

  p2qe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // signed numerators for the parabolic and linear heights
  always_comb begin
    sa    = dh_hi[S] ? -NW'(a_q) : NW'(a_q);
    sb    = dh_lo[S] ? -NW'(b_q) : NW'(b_q);
    nsum  = sa + sb;
    nfin  = dpos ? nsum : -nsum;
    nabs  = nfin[NW-1] ? -nfin : nfin;
    ln    = dpos ? {dh_hi[S], dh_hi} : -{dh_lo[S], dh_lo};
    lnabs = ln[S+1] ? -ln : ln;
  end

  p2qe_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .num_i     (mag_q),
    .den_i     (den_q),
    .done_o    (div_done),
    .quot_o    (quot),
    .inexact_o (inexact)
  );

  // truncated height from the quotient
  always_comb begin
    big   = (|quot[NUM_W-1:CB+1]) || (quot[CB] && (|quot[CB-1:0]));
    qm    = big ? QCLAMP : quot[CB:0];
    qmi   = VW'(qm) + VW'(inexact);
    fl    = neg_q ? -qmi : VW'(qm);
    v0    = VW'(yi) + fl;
    v     = (inexact && v0[VW-1]) ? v0 + VW'(1) : v0;
    yp_ok = ($signed(v) >= $signed(VW'(iy))) && ($signed(v) <= $signed(VW'(yii)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qf_q   <= p2qe_pkg::QF_RESET;
      seen_q <= '0;
      for (int i = 0; i < 5; i++) begin
        h_q[i]  <= '0;
        p_q[i]  <= '0;
        ds_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        qf_q <= cfg_wdata_i;
      end
      if (cmd_i.warm) begin
        seen_q         <= seen_q + 3'd1;
        h_q[seen_q]    <= q;
        p_q[seen_q]    <= PW'(seen_q) + PW'(1);
        if (seen_q == 3'd0) begin
          ds_q[0] <= PONE;
          ds_q[1] <= init1;
          ds_q[2] <= init2;
          ds_q[3] <= init3;
          ds_q[4] <= init4;
        end
      end
      if (cmd_i.update) begin
        if (q < h_q[0]) begin
          h_q[0] <= q;
        end
        if ((k == 3'd4) && (q > h_q[4])) begin
          h_q[4] <= q;
        end
        for (int i = 1; i < 5; i++) begin
          ds_q[i] <= ds_q[i] + inc[i];
          if (k <= 3'(i)) begin
            p_q[i] <= p_q[i] + PW'(1);
          end
        end
      end
      if (cmd_i.sort_en) begin
        if (!cmd_i.sort_odd) begin
          if (h_q[0] > h_q[1]) begin
            h_q[0] <= h_q[1];
            h_q[1] <= h_q[0];
          end
          if (h_q[2] > h_q[3]) begin
            h_q[2] <= h_q[3];
            h_q[3] <= h_q[2];
          end
        end else begin
          if (h_q[1] > h_q[2]) begin
            h_q[1] <= h_q[2];
            h_q[2] <= h_q[1];
          end
          if (h_q[3] > h_q[4]) begin
            h_q[3] <= h_q[4];
            h_q[4] <= h_q[3];
          end
        end
      end
      if (cmd_i.write) begin
        for (int i = 1; i < 4; i++) begin
          if (cmd_i.idx == 3'(i)) begin
            h_q[i] <= v[S-1:0];
            p_q[i] <= p_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      case (cmd_i.mop)
        p2qe_pkg::MOP_A_DH: a_q   <= mul_prod[AW-1:0];
        p2qe_pkg::MOP_B_DH: b_q   <= mul_prod[AW-1:0];
        p2qe_pkg::MOP_DEN:  den_q <= EW'(mul_prod);
        default:            tmp_q <= mul_prod[MA-1:0];
      endcase
    end
    if (cmd_i.num_par) begin
      mag_q <= nabs[NUM_W-1:0];
      neg_q <= nfin[NW-1];
    end
    if (cmd_i.num_lin) begin
      mag_q <= NUM_W'(lnabs[S:0]);
      neg_q <= ln[S+1];
      den_q <= EW'(dpos ? g_hi : g_lo);
    end
  end

  always_comb begin
    sts_o.seen_full = seen_q == 3'd5;
    sts_o.last_warm = seen_q == 3'd4;
    sts_o.move      = up || dn;
    sts_o.gaps_nz   = (g_lo != '0) && (g_hi != '0);
    sts_o.mul_done  = mul_done;
    sts_o.div_done  = div_done;
    sts_o.yp_ok     = yp_ok;
    sts_o.den_nz    = |den_q;
  end

  assign estimate_o = FW'(h_q[2]);

endmodule

[rtl/p2qe_ctrl.sv]
// controller: sequences warm-up, sort, cell update and the three marker adjustments
// depends on p2qe_pkg for state, operation, command and status types
module p2qe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  input  p2qe_pkg::sts_t  sts_i,
  output p2qe_pkg::cmd_t  cmd_o,
  output logic            in_ready_o
);

  p2qe_pkg::state_e state_q, state_d;
  p2qe_pkg::mop_e   mop_q, mop_d;
  logic [2:0]       idx_q, idx_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             lin_q, lin_d;
  logic             next_marker;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= p2qe_pkg::ST_IDLE;
      mop_q   <= p2qe_pkg::MOP_FA_GLO;
      idx_q   <= 3'd1;
      cnt_q   <= '0;
      lin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mop_q   <= mop_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      lin_q   <= lin_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    mop_d       = mop_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    lin_d       = lin_q;
    next_marker = 1'b0;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mop      = mop_q;
    cmd_o.idx      = idx_q;
    cmd_o.sort_odd = cnt_q[0];

    case (state_q)
      p2qe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.seen_full) begin
            cmd_o.update = 1'b1;
            idx_d        = 3'd1;
            state_d      = p2qe_pkg::ST_EVAL;
          end else begin
            cmd_o.warm = 1'b1;
            cnt_d      = '0;
            state_d    = sts_i.last_warm ? p2qe_pkg::ST_SORT : p2qe_pkg::ST_DONE;
          end
        end
      end
      p2qe_pkg::ST_SORT: begin
        cmd_o.sort_en = 1'b1;
        cnt_d         = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = p2qe_pkg::ST_DONE;
        end
      end
      p2qe_pkg::ST_EVAL: begin
        if (!sts_i.move) begin
          next_marker = 1'b1;
        end else if (sts_i.gaps_nz) begin
          mop_d   = p2qe_pkg::MOP_FA_GLO;
          lin_d   = 1'b0;
          state_d = p2qe_pkg::ST_MUL_GO;
        end else begin
          state_d = p2qe_pkg::ST_LIN;
        end
      end
      p2qe_pkg::ST_MUL_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = p2qe_pkg::ST_MUL_WAIT;
      end
      p2qe_pkg::ST_MUL_WAIT: begin
        if (sts_i.mul_done) begin
          state_d = p2qe_pkg::ST_MUL_GO;
          case (mop_q)
            p2qe_pkg::MOP_FA_GLO:  mop_d = p2qe_pkg::MOP_A_DH;
            p2qe_pkg::MOP_A_DH:    mop_d = p2qe_pkg::MOP_FB_GHI;
            p2qe_pkg::MOP_FB_GHI:  mop_d = p2qe_pkg::MOP_B_DH;
            p2qe_pkg::MOP_B_DH:    mop_d = p2qe_pkg::MOP_GHI_GLO;
            p2qe_pkg::MOP_GHI_GLO: mop_d = p2qe_pkg::MOP_DEN;
            default:               state_d = p2qe_pkg::ST_NUM;
          endcase
        end
      end
      p2qe_pkg::ST_NUM: begin
        cmd_o.num_par = 1'b1;
        state_d       = p2qe_pkg::ST_DIV_GO;
      end
      p2qe_pkg::ST_LIN: begin
        cmd_o.num_lin = 1'b1;
        lin_d         = 1'b1;
        state_d       = p2qe_pkg::ST_DIV_GO;
      end
      p2qe_pkg::ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = p2qe_pkg::ST_DIV_WAIT;
      end
      p2qe_pkg::ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = p2qe_pkg::ST_CHECK;
        end
      end
      p2qe_pkg::ST_CHECK: begin
        if (lin_q || sts_i.yp_ok) begin
          cmd_o.write = 1'b1;
          next_marker = 1'b1;
        end else begin
          state_d = p2qe_pkg::ST_LIN;
        end
      end
      p2qe_pkg::ST_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = p2qe_pkg::ST_IDLE;
        end
      end
      default: state_d = p2qe_pkg::ST_IDLE;
    endcase

    if (next_marker) begin
      if (idx_q == 3'd3) begin
        state_d = p2qe_pkg::ST_DONE;
      end else begin
        idx_d   = idx_q + 3'd1;
        state_d = p2qe_pkg::ST_EVAL;
      end
    end
  end

endmodule
